### rtl/core/acfp_pkg.sv
package acfp_pkg;

  // Characters of the frame AT+<cmd>:<param>\r\n
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Result kinds
  localparam logic [1:0] KIND_HDR   = 2'd0;
  localparam logic [1:0] KIND_CMD   = 2'd1;
  localparam logic [1:0] KIND_PARAM = 2'd2;

  // Parse states
  localparam logic [2:0] PS_IDLE  = 3'd0;
  localparam logic [2:0] PS_A     = 3'd1;
  localparam logic [2:0] PS_AT    = 3'd2;
  localparam logic [2:0] PS_CMD   = 3'd3;
  localparam logic [2:0] PS_PARAM = 3'd4;
  localparam logic [2:0] PS_CR    = 3'd5;

  // Sequencer modes
  localparam logic [1:0] MODE_PARSE = 2'd0;
  localparam logic [1:0] MODE_HDR   = 2'd1;
  localparam logic [1:0] MODE_FETCH = 2'd2;
  localparam logic [1:0] MODE_LOAD  = 2'd3;

  typedef logic [7:0] byte_t;

endpackage

### rtl/core/at_command_frame_parser.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// in       | input     | in_valid/in_stall  | in_rx_byte[7:0]
// out      | output    | out_valid/out_stall| out_kind, out_data_byte, out_cmd_length,
//          |           |                    | out_param_length, out_last
//
// A byte is taken whenever in_valid is high and no frame is being read out.
// A closing LF starts the readout: one header, then each stored command and
// parameter byte; each stored byte is read from its store in the FETCH state and
// then loaded into the output register in the LOAD state.
// in_stall stays high during readout. out_stall holds the output register and
// stalls the readout. Synchronous active-low reset; stores need no clearing.
module at_command_frame_parser #(
  parameter int CMD_DEPTH   = 16,
  parameter int PARAM_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [3:0] out_cmd_length,
  output logic [4:0] out_param_length,
  output logic       out_last
);

  localparam int CCW = $clog2(CMD_DEPTH);
  localparam int PCW = $clog2(PARAM_DEPTH);

  acfp_pkg::byte_t cmd_mem [CMD_DEPTH];
  acfp_pkg::byte_t par_mem [PARAM_DEPTH];

  logic [2:0]     pstate_r, pstate_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [CCW-1:0] cmd_count_r, cmd_count_nxt;
  logic [PCW-1:0] par_count_r, par_count_nxt;
  logic [CCW-1:0] cmd_idx_r, cmd_idx_nxt;
  logic [PCW-1:0] par_idx_r, par_idx_nxt;
  logic           par_phase_r, par_phase_nxt;

  acfp_pkg::byte_t cmd_rdata_r, par_rdata_r;

  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_kind_r, out_kind_nxt;
  logic [7:0]     out_data_r, out_data_nxt;
  logic [3:0]     out_clen_r, out_clen_nxt;
  logic [4:0]     out_plen_r, out_plen_nxt;
  logic           out_last_r, out_last_nxt;

  logic           in_acc, out_free, load, rd_en;
  logic           cmd_we, par_we;
  logic           cmd_end, par_end, item_last;
  logic [CCW+3:0] cmd_len_wide;
  logic [PCW+4:0] par_len_wide;

  assign in_stall = (mode_r != acfp_pkg::MODE_PARSE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_en    = (mode_r == acfp_pkg::MODE_FETCH);

  assign cmd_end   = (cmd_idx_r == cmd_count_r - CCW'(1));
  assign par_end   = (par_idx_r == par_count_r - PCW'(1));
  assign item_last = par_phase_r ? par_end : (cmd_end && (par_count_r == '0));

  assign cmd_len_wide = {4'b0, cmd_count_r};
  assign par_len_wide = {5'b0, par_count_r};

  always_comb begin
    pstate_nxt    = pstate_r;
    mode_nxt      = mode_r;
    cmd_count_nxt = cmd_count_r;
    par_count_nxt = par_count_r;
    cmd_idx_nxt   = cmd_idx_r;
    par_idx_nxt   = par_idx_r;
    par_phase_nxt = par_phase_r;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_clen_nxt  = out_clen_r;
    out_plen_nxt  = out_plen_r;
    out_last_nxt  = out_last_r;
    cmd_we        = 1'b0;
    par_we        = 1'b0;
    load          = 1'b0;

    case (mode_r)
      acfp_pkg::MODE_PARSE: begin
        if (in_acc) begin
          case (pstate_r)
            acfp_pkg::PS_IDLE: begin
              if (in_rx_byte == acfp_pkg::CH_A) pstate_nxt = acfp_pkg::PS_A;
            end
            acfp_pkg::PS_A: begin
              pstate_nxt = (in_rx_byte == acfp_pkg::CH_T) ? acfp_pkg::PS_AT
                                                          : acfp_pkg::PS_IDLE;
            end
            acfp_pkg::PS_AT: begin
              if (in_rx_byte == acfp_pkg::CH_PLUS) begin
                pstate_nxt    = acfp_pkg::PS_CMD;
                cmd_count_nxt = '0;
              end else begin
                pstate_nxt = acfp_pkg::PS_IDLE;
              end
            end
            acfp_pkg::PS_CMD: begin
              if (in_rx_byte == acfp_pkg::CH_COLON) begin
                pstate_nxt    = acfp_pkg::PS_PARAM;
                par_count_nxt = '0;
              end else if (cmd_count_r < CCW'(CMD_DEPTH - 1)) begin
                cmd_we        = 1'b1;
                cmd_count_nxt = cmd_count_r + CCW'(1);
              end else begin
                pstate_nxt = acfp_pkg::PS_IDLE;
              end
            end
            acfp_pkg::PS_PARAM: begin
              if (in_rx_byte == acfp_pkg::CH_CR) begin
                pstate_nxt = acfp_pkg::PS_CR;
              end else if (par_count_r < PCW'(PARAM_DEPTH - 2)) begin
                par_we        = 1'b1;
                par_count_nxt = par_count_r + PCW'(1);
              end else begin
                pstate_nxt = acfp_pkg::PS_IDLE;
              end
            end
            acfp_pkg::PS_CR: begin
              if (in_rx_byte == acfp_pkg::CH_LF) mode_nxt = acfp_pkg::MODE_HDR;
              pstate_nxt = acfp_pkg::PS_IDLE;
            end
            default: pstate_nxt = acfp_pkg::PS_IDLE;
          endcase
        end
      end
      acfp_pkg::MODE_HDR: begin
        if (out_free) begin
          load          = 1'b1;
          out_kind_nxt  = acfp_pkg::KIND_HDR;
          out_data_nxt  = '0;
          out_last_nxt  = (cmd_count_r == '0) && (par_count_r == '0);
          cmd_idx_nxt   = '0;
          par_idx_nxt   = '0;
          par_phase_nxt = (cmd_count_r == '0);
          mode_nxt      = out_last_nxt ? acfp_pkg::MODE_PARSE : acfp_pkg::MODE_FETCH;
        end
      end
      acfp_pkg::MODE_FETCH: begin
        mode_nxt = acfp_pkg::MODE_LOAD;
      end
      acfp_pkg::MODE_LOAD: begin
        if (out_free) begin
          load         = 1'b1;
          out_kind_nxt = par_phase_r ? acfp_pkg::KIND_PARAM : acfp_pkg::KIND_CMD;
          out_data_nxt = par_phase_r ? par_rdata_r : cmd_rdata_r;
          out_last_nxt = item_last;
          if (item_last) begin
            mode_nxt = acfp_pkg::MODE_PARSE;
          end else begin
            mode_nxt = acfp_pkg::MODE_FETCH;
            if (par_phase_r) begin
              par_idx_nxt = par_idx_r + PCW'(1);
            end else if (cmd_end) begin
              par_phase_nxt = 1'b1;
            end else begin
              cmd_idx_nxt = cmd_idx_r + CCW'(1);
            end
          end
        end
      end
      default: mode_nxt = acfp_pkg::MODE_PARSE;
    endcase

    // lengths travel with the beat so new input cannot disturb a held result
    if (load) begin
      out_valid_nxt = 1'b1;
      out_clen_nxt  = cmd_len_wide[3:0];
      out_plen_nxt  = par_len_wide[4:0];
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstate_r    <= acfp_pkg::PS_IDLE;
      mode_r      <= acfp_pkg::MODE_PARSE;
      cmd_count_r <= '0;
      par_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pstate_r    <= pstate_nxt;
      mode_r      <= mode_nxt;
      cmd_count_r <= cmd_count_nxt;
      par_count_r <= par_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_idx_r   <= cmd_idx_nxt;
    par_idx_r   <= par_idx_nxt;
    par_phase_r <= par_phase_nxt;
    out_kind_r  <= out_kind_nxt;
    out_data_r  <= out_data_nxt;
    out_clen_r  <= out_clen_nxt;
    out_plen_r  <= out_plen_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Stores: written while parsing, read only during readout (input stalled).
  always_ff @(posedge clk) begin
    if (cmd_we) cmd_mem[cmd_count_r] <= in_rx_byte;
    if (rd_en)  cmd_rdata_r <= cmd_mem[cmd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_count_r] <= in_rx_byte;
    if (rd_en)  par_rdata_r <= par_mem[par_idx_r];
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_data_byte    = out_data_r;
  assign out_cmd_length   = out_clen_r;
  assign out_param_length = out_plen_r;
  assign out_last         = out_last_r;

  a_fetch_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == acfp_pkg::MODE_FETCH |=> mode_r == acfp_pkg::MODE_LOAD)
    else $error("readout fetch not followed by load");

  a_hdr_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == acfp_pkg::KIND_HDR |-> out_data_byte == 8'h00)
    else $error("header carries nonzero data");

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_we || par_we) |-> mode_r == acfp_pkg::MODE_PARSE)
    else $error("store write during readout");

  a_last_ends_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |->
      mode_r == acfp_pkg::MODE_PARSE || mode_r == acfp_pkg::MODE_HDR)
    else $error("readout still running after last beat");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && !load |=> out_valid && $stable(out_data_byte) &&
      $stable(out_cmd_length) && $stable(out_param_length))
    else $error("output beat changed while stalled");

endmodule
